>>> src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/pstp_pkg.sv
// Types and constants of the PSI section packetizer.
package pstp_pkg;

  localparam logic [7:0] SYNC_BYTE    = 8'h47;
  localparam logic [7:0] PUSI_FLAG    = 8'h40;
  localparam logic [7:0] PAYLOAD_ONLY = 8'h10;
  localparam logic [7:0] STUFF_BYTE   = 8'hff;
  localparam logic [7:0] POINTER_BYTE = 8'h00;
  localparam logic [7:0] TS_BYTES     = 8'd188;
  localparam int unsigned WORDS_PER_PACKET = 47;

  localparam int unsigned PID_W  = 13;
  localparam int unsigned CONT_W = 4;

  // register indexes
  localparam logic REG_PID  = 1'b0;
  localparam logic REG_CONT = 1'b1;

  typedef struct packed {
    logic [7:0] section_byte;
    logic       last_byte;
    logic [7:0] table_tag;
  } in_word_t;

  typedef struct packed {
    logic [31:0] packet_word;
    logic        packet_end;
    logic [7:0]  out_tag;
    logic        last_of_run;
  } out_word_t;

  typedef struct packed {
    logic              cont_load;
    logic [CONT_W-1:0] cont_value;
  } cfg_ctl_t;

endpackage

>>> src/psi_section_ts_packetizer_unit.sv
// Top level of the PSI section to transport packet packetizer.
//
//  channel  dir  handshake              payload
//  -------  ---  ---------------------  ---------------------------------------
//  in       in   in_valid / in_ready    in_data: section_byte, last_byte, tag
//  out      out  out_valid / out_ready  out_data: packet_word, packet_end,
//                                                 out_tag, last_of_run
//  cfg      in   cfg_write (no wait)    cfg_index, cfg_data
//
//  The packer moves one packet byte per cycle while it is not stalled: a payload
//  byte in an open packet goes out as is, opening a packet adds 4 header bytes (5
//  with the pointer byte), and a section's last byte is followed by stuffing to
//  the packet end. A word leaves every fourth byte; the byte loop stalls when a
//  word is due and the output register still holds an untaken word, or while
//  idle with an empty queue. The input queue (QUEUE_DEPTH words) keeps accepting
//  while not full. Reset is synchronous: queue empty, no packet open, next byte
//  starts a section, continuity counter 0.
module psi_section_ts_packetizer_unit import pstp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);

  logic [PID_W-1:0] pid;
  cfg_ctl_t         cfg_ctl;
  logic             head_valid;
  in_word_t         head;
  logic             pop;

  // pid is read only while a header is built
  always_ff @(posedge clk) begin
    if (rst) begin
      pid <= '0;
    end else if (cfg_write && (cfg_index == REG_PID)) begin
      pid <= cfg_data;
    end
  end

  // a REG_CONT write loads the running counter directly
  assign cfg_ctl.cont_load  = cfg_write && (cfg_index == REG_CONT);
  assign cfg_ctl.cont_value = cfg_data[CONT_W-1:0];

  pstp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  pstp_packer u_packer (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .pid        (pid),
    .cfg_ctl    (cfg_ctl),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

>>> src/pstp_queue.sv
// Input queue: accepts section words and holds them for the packer.
module pstp_queue import pstp_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_data,
  output logic     head_valid,
  output in_word_t head,
  input  logic     pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  in_word_t         slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             do_pop;

  assign in_ready   = (count != FULL_CNT);
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign push       = in_valid && in_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/pstp_packer.sv
// Packet builder: header, pointer, payload and stuffing, one byte a cycle unless stalled.
module pstp_packer import pstp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  in_word_t         head,
  output logic             pop,
  input  logic [PID_W-1:0] pid,
  input  cfg_ctl_t         cfg_ctl,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data
);

  localparam logic [2:0] ST_START = 3'd0;
  localparam logic [2:0] ST_H1    = 3'd1;
  localparam logic [2:0] ST_H2    = 3'd2;
  localparam logic [2:0] ST_H3    = 3'd3;
  localparam logic [2:0] ST_PTR   = 3'd4;
  localparam logic [2:0] ST_DATA  = 3'd5;
  localparam logic [2:0] ST_STUFF = 3'd6;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [7:0]        pos;
  logic [23:0]       partial;
  logic [CONT_W-1:0] cont;
  logic              sstart;
  logic              popen;

  logic [7:0]  cur_byte;
  logic        is_data;
  logic        is_stuff;
  logic        active;
  logic        go;
  logic [7:0]  pos_inc;
  logic        word_done;
  logic        pkt_end;
  logic        item_done;
  logic [31:0] word;

  assign pos_inc   = pos + 8'd1;
  assign word_done = (pos_inc[1:0] == 2'b00);
  assign pkt_end   = (pos_inc == TS_BYTES);
  assign word      = {partial, cur_byte};
  assign active    = (state != ST_START) || head_valid;
  assign go        = active && (!word_done || !out_valid || out_ready);
  assign is_data   = ((state == ST_START) && popen) || (state == ST_DATA);
  assign is_stuff  = (state == ST_STUFF);

  always_comb begin
    cur_byte   = STUFF_BYTE;
    state_next = state;
    item_done  = 1'b0;
    unique case (state)
      ST_START: begin
        cur_byte = popen ? head.section_byte : SYNC_BYTE;
        if (!popen) begin
          state_next = ST_H1;
        end
      end
      ST_H1: begin
        cur_byte   = (sstart ? PUSI_FLAG : 8'h00) | {3'b000, pid[12:8]};
        state_next = ST_H2;
      end
      ST_H2: begin
        cur_byte   = pid[7:0];
        state_next = ST_H3;
      end
      ST_H3: begin
        cur_byte   = PAYLOAD_ONLY | {4'h0, cont};
        state_next = sstart ? ST_PTR : ST_DATA;
      end
      ST_PTR: begin
        cur_byte   = POINTER_BYTE;
        state_next = ST_DATA;
      end
      ST_DATA: begin
        cur_byte = head.section_byte;
      end
      ST_STUFF: begin
        cur_byte = STUFF_BYTE;
        if (pkt_end) begin
          state_next = ST_START;
          item_done  = 1'b1;
        end
      end
      default: begin
        state_next = ST_START;
      end
    endcase
    // data byte: go stuffing on a last byte that leaves the packet open
    if (is_data) begin
      if (head.last_byte && !pkt_end) begin
        state_next = ST_STUFF;
      end else begin
        state_next = ST_START;
        item_done  = 1'b1;
      end
    end
  end

  assign pop = go && item_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_START;
      pos     <= '0;
      partial <= '0;
      cont    <= '0;
      sstart  <= 1'b1;
      popen   <= 1'b0;
    end else begin
      if (go) begin
        state   <= state_next;
        partial <= word_done ? 24'h0 : word[23:0];
        if (pkt_end) begin
          pos   <= '0;
          popen <= 1'b0;
          cont  <= cont + 1'b1;
        end else begin
          pos <= pos_inc;
        end
        if ((state == ST_START) && !popen) begin
          popen <= 1'b1;
        end
        if (is_data) begin
          sstart <= head.last_byte;
        end
      end
      if (cfg_ctl.cont_load) begin
        cont <= cfg_ctl.cont_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && word_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // header word closes the run when the data byte after it completes no word
  always_ff @(posedge clk) begin
    if (go && word_done) begin
      out_data.packet_word <= word;
      out_data.packet_end  <= pkt_end;
      out_data.out_tag     <= head.table_tag;
      out_data.last_of_run <= (is_data && (!head.last_byte || pkt_end)) ||
                              (is_stuff && pkt_end) ||
                              ((state == ST_H3) && !head.last_byte);
    end
  end

endmodule

>>> src/pstp_checker.sv
// Port-level checks of the packetizer, bound to the top level.
`include "assert_macros.svh"

module pstp_checker import pstp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input out_word_t   out_data
);

  localparam logic [5:0] LAST_WORD = 6'(WORDS_PER_PACKET - 1);

  // word position inside the current packet on the out channel
  logic [5:0] word_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_idx <= '0;
    end else if (out_valid && out_ready) begin
      word_idx <= (word_idx == LAST_WORD) ? 6'd0 : word_idx + 6'd1;
    end
  end

  `ASSERT_CLK_ALWAYS(a_idle_after_reset, clk,
    ($past(rst) && !rst) |-> !out_valid, "out_valid after reset")

  `ASSERT_CLK(a_out_hold, clk, rst,
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "stalled word changed")

  `ASSERT_CLK(a_end_on_47th, clk, rst,
    out_valid |-> (out_data.packet_end == (word_idx == LAST_WORD)), "packet_end misplaced")

  `ASSERT_CLK(a_sync_first, clk, rst,
    (out_valid && (word_idx == 6'd0)) |-> (out_data.packet_word[31:24] == SYNC_BYTE),
    "packet does not open with sync")

  `ASSERT_CLK(a_end_closes_run, clk, rst,
    (out_valid && out_data.packet_end) |-> out_data.last_of_run, "end word not last of run")

endmodule

bind psi_section_ts_packetizer_unit pstp_checker u_pstp_checker (.*);
